// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TNC_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define TNC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tnc_pkg.sv =====
// ----------------------------------------------------------------------------
// tnc_pkg
// Types and constants shared by the toroidal neighbor count block.
// ----------------------------------------------------------------------------
package tnc_pkg;

	localparam int CELLS_W   = 64;
	localparam int ROW_IDX_W = 6;
	localparam int COL_W     = 6;
	localparam int COUNT_W   = 4;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ser_status_t;

endpackage

// ===== rtl/tnc_row_store.sv =====
// ----------------------------------------------------------------------------
// tnc_row_store
// Grid memory, one row per entry, with a per-row valid bit that makes
// never-loaded rows read as all dead.
// ----------------------------------------------------------------------------
module tnc_row_store #(
	parameter int GRID_SIZE = 64,
	parameter int ROW_W     = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [ROW_W-1:0]     wr_addr,
	input  logic [GRID_SIZE-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [ROW_W-1:0]     rd_addr,
	output logic [GRID_SIZE-1:0] rd_data
);

	logic [GRID_SIZE-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0] valid_q;
	logic [GRID_SIZE-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/tnc_lane.sv =====
// ----------------------------------------------------------------------------
// tnc_lane
// Counts the live cells among the eight neighbors of one column.
// ----------------------------------------------------------------------------
module tnc_lane
	import tnc_pkg::*;
(
	input  logic [7:0]         neighbors,
	output logic [COUNT_W-1:0] count
);

	always_comb begin
		count = '0;
		for (int i = 0; i < 8; i++) begin
			count = count + COUNT_W'(neighbors[i]);
		end
	end

endmodule

// ===== rtl/tnc_serializer.sv =====
// ----------------------------------------------------------------------------
// tnc_serializer
// Takes the counts of all lanes at once and sends them out one column per
// beat, lowest column first.
// ----------------------------------------------------------------------------
module tnc_serializer
	import tnc_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [GRID_SIZE*COUNT_W-1:0] counts,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [M_TDATA_W-1:0]         m_tdata,
	output logic                         m_tlast,
	output ser_status_t                  status
);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_SIZE - 1);

	logic [GRID_SIZE*COUNT_W-1:0] counts_q;
	logic [COL_W-1:0]             col_q;
	logic                         busy_q;
	logic                         beat;
	logic                         last;

	assign last = (col_q == LAST_COL);
	assign beat = busy_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= '0;
		end else if (beat) begin
			col_q <= col_q + COL_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			counts_q <= counts;
		end else if (beat) begin
			counts_q <= {COUNT_W'(0), counts_q[GRID_SIZE*COUNT_W-1:COUNT_W]};
		end
	end

	assign m_tvalid    = busy_q;
	assign m_tdata     = {{(M_TDATA_W - COL_W - COUNT_W){1'b0}}, counts_q[COUNT_W-1:0], col_q};
	assign m_tlast     = last;
	assign status.busy = busy_q;
	assign status.done = beat & last;

endmodule

// ===== rtl/toroidal_neighbor_count.sv =====
// ----------------------------------------------------------------------------
// toroidal_neighbor_count
// Square live/dead grid with wrap-around neighbor counts, one row at a time.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one packed row; a load or read of a row at
// or beyond GRID_SIZE is taken and dropped. A read beat (tuser = 1) fetches
// the row above, the row itself and the row below through the single read
// port of the row store, forms all column counts at once in one lane per
// column and then sends GRID_SIZE result beats, one per cycle while m_tready
// is high. No new beat is taken until the last result of a read is sent.
// The grid reads as all dead after reset, with no clearing pass.
module toroidal_neighbor_count
	import tnc_pkg::*;
#(
	parameter int GRID_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [5:0] row_index, [69:6] row_cells, [71:70] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] command
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [5:0] column_index, [9:6] neighbor_count, [15:10] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// last_of_row
	output logic                 m_tlast
);

	`include "assert_macros.svh"

	localparam int ROW_W = $clog2(GRID_SIZE);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);

	state_t                       state_q, state_d;
	logic [1:0]                   step_q;
	logic [ROW_W-1:0]             row_sel_q;
	logic [GRID_SIZE-1:0]         win_up_q, win_mid_q;
	logic [GRID_SIZE-1:0]         rd_row;
	logic [ROW_W-1:0]             row_up, row_dn, rd_addr;
	logic                         in_beat, row_ok, wr_en, rd_en, ser_load;
	logic [GRID_SIZE*COUNT_W-1:0] counts;
	ser_status_t                  ser_status;

	assign in_beat = s_tvalid & s_tready;
	assign row_ok  = ({1'b0, s_tdata[ROW_IDX_W-1:0]} < (ROW_IDX_W + 1)'(GRID_SIZE));
	assign wr_en   = in_beat & row_ok & (s_tuser == CMD_LOAD);

	assign row_up = (row_sel_q == '0) ? LAST_ROW : row_sel_q - ROW_W'(1);
	assign row_dn = (row_sel_q == LAST_ROW) ? '0 : row_sel_q + ROW_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat && row_ok && s_tuser == CMD_READ) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				if (step_q == 2'd2) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (ser_status.done) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		ser_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_FETCH: rd_en    = 1'b1;
			ST_CALC:  ser_load = 1'b1;
			default: begin
			end
		endcase
	end

	always_comb begin
		case (step_q)
			2'd0:    rd_addr = row_up;
			2'd2:    rd_addr = row_dn;
			default: rd_addr = row_sel_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FETCH) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_beat) begin
			row_sel_q <= s_tdata[ROW_W-1:0];
		end
		// Rows arrive in the cycle after their address: above, then the row itself.
		if (state_q == ST_FETCH && step_q != 2'd0) begin
			win_up_q  <= win_mid_q;
			win_mid_q <= rd_row;
		end
	end

	tnc_row_store #(
		.GRID_SIZE (GRID_SIZE),
		.ROW_W     (ROW_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (s_tdata[ROW_W-1:0]),
		.wr_data (s_tdata[ROW_IDX_W +: GRID_SIZE]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_row)
	);

	// In the calc cycle the row below is on the store output.
	for (genvar c = 0; c < GRID_SIZE; c++) begin : g_lane
		localparam int LF = (c == 0) ? GRID_SIZE - 1 : c - 1;
		localparam int RT = (c == GRID_SIZE - 1) ? 0 : c + 1;
		tnc_lane u_lane (
			.neighbors ({win_up_q[LF], win_up_q[c], win_up_q[RT],
			             win_mid_q[LF], win_mid_q[RT],
			             rd_row[LF], rd_row[c], rd_row[RT]}),
			.count     (counts[c*COUNT_W +: COUNT_W])
		);
	end

	tnc_serializer #(
		.GRID_SIZE (GRID_SIZE)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ser_load),
		.counts   (counts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.status   (ser_status)
	);

	`TNC_ASSERT_IMPL(a_out_only_in_emit, m_tvalid, state_q == ST_EMIT, "result beat outside emit")
	`TNC_ASSERT(a_no_overlap, !(s_tready && ser_status.busy), "input taken while results pending")
	`TNC_ASSERT_IMPL(a_idle_after_last, $past(m_tvalid && m_tready && m_tlast), state_q == ST_IDLE, "no return to idle after last beat")

endmodule
